[design/sha1_pkg.sv]
package sha1_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BLK_W    = 512;
  localparam int unsigned RND_W    = 7;
  localparam int unsigned NUM_WORD = 5;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned CNT_W    = 61;

  localparam logic [RND_W-1:0] RND_LAST = 7'd79;
  localparam logic [5:0]       POS_LAST = 6'd63;
  localparam logic [5:0]       POS_LEN  = 6'd56;
  localparam logic [IDX_W-1:0] IDX_LAST = 3'd4;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  localparam logic [WORD_W-1:0] H0_INIT = 32'h67452301;
  localparam logic [WORD_W-1:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [WORD_W-1:0] H2_INIT = 32'h98BADCFE;
  localparam logic [WORD_W-1:0] H3_INIT = 32'h10325476;
  localparam logic [WORD_W-1:0] H4_INIT = 32'hC3D2E1F0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             byte_en;
    logic             round_en;
    logic             load_work;
    logic             add_chain;
    logic             init_chain;
    logic [RND_W-1:0] rnd;
    logic [IDX_W-1:0] rd_idx;
  } ctl_t;

  function automatic logic [WORD_W-1:0] f_fn(input logic [RND_W-1:0] rnd,
                                             input logic [WORD_W-1:0] b,
                                             input logic [WORD_W-1:0] c,
                                             input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] res;
    if (rnd < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      res = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] k_fn(input logic [RND_W-1:0] rnd);
    logic [WORD_W-1:0] res;
    if (rnd < 7'd20) begin
      res = K0;
    end else if (rnd < 7'd40) begin
      res = K1;
    end else if (rnd < 7'd60) begin
      res = K2;
    end else begin
      res = K3;
    end
    return res;
  endfunction

endpackage

[design/sha1_sched.sv]
module sha1_sched (
  input  logic                         clk,
  input  sha1_pkg::ctl_t               ctl,
  input  logic [7:0]                   byte_in,
  output logic [sha1_pkg::WORD_W-1:0]  w_cur
);

  // block held as a shift line: bytes enter at the bottom, rounds shift out words
  logic [sha1_pkg::BLK_W-1:0]  blk_r;
  logic [sha1_pkg::BLK_W-1:0]  blk_nxt;
  logic [sha1_pkg::WORD_W-1:0] mix;
  logic [sha1_pkg::WORD_W-1:0] w_new;

  assign w_cur = blk_r[511:480];
  assign mix   = blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ blk_r[511:480];
  assign w_new = {mix[30:0], mix[31]};

  always_comb begin
    blk_nxt = blk_r;
    if (ctl.byte_en) begin
      blk_nxt = {blk_r[503:0], byte_in};
    end else if (ctl.round_en) begin
      blk_nxt = {blk_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

[design/sha1_comp.sv]
module sha1_comp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sha1_pkg::ctl_t               ctl,
  input  logic [sha1_pkg::WORD_W-1:0]  w_cur,
  output logic [sha1_pkg::WORD_W-1:0]  digest_word
);

  logic [sha1_pkg::WORD_W-1:0] a_r, b_r, c_r, d_r, e_r;
  logic [sha1_pkg::WORD_W-1:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [sha1_pkg::WORD_W-1:0] h_r   [sha1_pkg::NUM_WORD];
  logic [sha1_pkg::WORD_W-1:0] h_nxt [sha1_pkg::NUM_WORD];
  logic [sha1_pkg::WORD_W-1:0] t_sum;

  assign t_sum = {a_r[26:0], a_r[31:27]} + sha1_pkg::f_fn(ctl.rnd, b_r, c_r, d_r)
               + e_r + sha1_pkg::k_fn(ctl.rnd) + w_cur;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    if (ctl.load_work) begin
      a_nxt = h_r[0];
      b_nxt = h_r[1];
      c_nxt = h_r[2];
      d_nxt = h_r[3];
      e_nxt = h_r[4];
    end else if (ctl.round_en) begin
      a_nxt = t_sum;
      b_nxt = a_r;
      c_nxt = {b_r[1:0], b_r[31:2]};
      d_nxt = c_r;
      e_nxt = d_r;
    end
  end

  always_comb begin
    h_nxt = h_r;
    if (ctl.init_chain) begin
      h_nxt[0] = sha1_pkg::H0_INIT;
      h_nxt[1] = sha1_pkg::H1_INIT;
      h_nxt[2] = sha1_pkg::H2_INIT;
      h_nxt[3] = sha1_pkg::H3_INIT;
      h_nxt[4] = sha1_pkg::H4_INIT;
    end else if (ctl.add_chain) begin
      h_nxt[0] = h_r[0] + a_r;
      h_nxt[1] = h_r[1] + b_r;
      h_nxt[2] = h_r[2] + c_r;
      h_nxt[3] = h_r[3] + d_r;
      h_nxt[4] = h_r[4] + e_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r[0] <= sha1_pkg::H0_INIT;
      h_r[1] <= sha1_pkg::H1_INIT;
      h_r[2] <= sha1_pkg::H2_INIT;
      h_r[3] <= sha1_pkg::H3_INIT;
      h_r[4] <= sha1_pkg::H4_INIT;
    end else begin
      h_r <= h_nxt;
    end
  end

  always_comb begin
    case (ctl.rd_idx)
      3'd0:    digest_word = h_r[0];
      3'd1:    digest_word = h_r[1];
      3'd2:    digest_word = h_r[2];
      3'd3:    digest_word = h_r[3];
      default: digest_word = h_r[4];
    endcase
  end

endmodule

[design/sha1_ctrl.sv]
module sha1_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_op,
  input  logic [7:0]                  in_data_byte,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sha1_pkg::IDX_W-1:0]  word_index,
  output logic [7:0]                  byte_out,
  output sha1_pkg::ctl_t              ctl
);

  sha1_pkg::state_t state_r, state_nxt;

  logic [sha1_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]                len_r, len_nxt;
  logic                       mark_r, mark_nxt;
  logic                       len_on_r, len_on_nxt;
  logic [sha1_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic [sha1_pkg::IDX_W-1:0] idx_r, idx_nxt;

  logic       in_acc, out_acc, emit_done;
  logic [5:0] pos;
  logic       is_len;
  logic [7:0] pad_byte;

  assign pos       = cnt_r[5:0];
  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;
  assign emit_done = out_acc && (idx_r == sha1_pkg::IDX_LAST);
  assign is_len    = mark_r && (len_on_r || (pos == sha1_pkg::POS_LEN));

  // padding byte: marker, zero fill, then length big-endian
  always_comb begin
    if (!mark_r) begin
      pad_byte = sha1_pkg::PAD_MARK;
    end else if (is_len) begin
      pad_byte = len_r[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_op == sha1_pkg::OP_FINISH) begin
            state_nxt = sha1_pkg::ST_PAD;
          end else if (pos == sha1_pkg::POS_LAST) begin
            state_nxt = sha1_pkg::ST_ROUND;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        if (pos == sha1_pkg::POS_LAST) begin
          state_nxt = sha1_pkg::ST_ROUND;
        end
      end
      sha1_pkg::ST_ROUND: begin
        if (rnd_r == sha1_pkg::RND_LAST) begin
          state_nxt = sha1_pkg::ST_ADD;
        end
      end
      sha1_pkg::ST_ADD: begin
        if (!mark_r) begin
          state_nxt = sha1_pkg::ST_IDLE;
        end else if (len_on_r) begin
          state_nxt = sha1_pkg::ST_EMIT;
        end else begin
          state_nxt = sha1_pkg::ST_PAD;
        end
      end
      sha1_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_nxt = sha1_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha1_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    byte_out       = pad_byte;
    ctl.byte_en    = 1'b0;
    ctl.round_en   = 1'b0;
    ctl.add_chain  = 1'b0;
    ctl.init_chain = 1'b0;
    ctl.load_work  = (state_nxt == sha1_pkg::ST_ROUND) && (state_r != sha1_pkg::ST_ROUND);
    ctl.rnd        = rnd_r;
    ctl.rd_idx     = idx_r;
    unique case (state_r)
      sha1_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        byte_out    = in_data_byte;
        ctl.byte_en = in_acc && (in_op == sha1_pkg::OP_ABSORB);
      end
      sha1_pkg::ST_PAD:   ctl.byte_en   = 1'b1;
      sha1_pkg::ST_ROUND: ctl.round_en  = 1'b1;
      sha1_pkg::ST_ADD:   ctl.add_chain = 1'b1;
      sha1_pkg::ST_EMIT: begin
        out_valid      = 1'b1;
        ctl.init_chain = emit_done;
      end
      default: ;
    endcase
  end

  assign word_index = idx_r;

  always_comb begin
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    mark_nxt   = mark_r;
    len_on_nxt = len_on_r;
    rnd_nxt    = '0;
    idx_nxt    = idx_r;
    if (ctl.byte_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (state_r == sha1_pkg::ST_IDLE && in_acc && in_op == sha1_pkg::OP_FINISH) begin
      len_nxt = {cnt_r, 3'b000};
    end
    if (state_r == sha1_pkg::ST_PAD) begin
      mark_nxt = 1'b1;
      if (is_len) begin
        len_on_nxt = 1'b1;
        len_nxt    = {len_r[55:0], 8'h00};
      end
    end
    if (state_r == sha1_pkg::ST_ROUND) begin
      rnd_nxt = rnd_r + 1'b1;
    end
    if (out_acc) begin
      idx_nxt = emit_done ? '0 : idx_r + 1'b1;
    end
    if (emit_done) begin
      cnt_nxt    = '0;
      mark_nxt   = 1'b0;
      len_on_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sha1_pkg::ST_IDLE;
      cnt_r    <= '0;
      mark_r   <= 1'b0;
      len_on_r <= 1'b0;
      rnd_r    <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      mark_r   <= mark_nxt;
      len_on_r <= len_on_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha1_pkg::ST_ROUND |-> rnd_r <= sha1_pkg::RND_LAST)
    else $error("round counter overran");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while digest pending");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha1_pkg::ST_EMIT |-> idx_r <= sha1_pkg::IDX_LAST)
    else $error("digest word index out of range");

  a_pad_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1_pkg::ST_PAD && pos == sha1_pkg::POS_LAST) |=>
      state_r == sha1_pkg::ST_ROUND)
    else $error("full padded block not compressed");

  a_emit_after_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha1_pkg::ST_EMIT |-> (mark_r && len_on_r))
    else $error("digest emitted before length was padded");

endmodule

[design/sha1_stream_hasher.sv]
// SHA-1 over a byte stream. Each absorb item (op 0) carries one message byte;
// the byte that completes a 64-byte block additionally starts the compression,
// one round per cycle through a single shared round unit, then the chaining
// add. A finish item (op 1) pads byte by byte through the same block shift
// line (0x80, zero fill, 64-bit big-endian bit length), runs one or two
// compressions, then offers the five digest words h0..h4 on the out channel,
// out_last set on the fifth. The chaining words return to their initial values
// and the bit count to zero once the fifth word is taken. in_ready is low from
// a block-completing or finish item until the block work, or the digest, is
// done. No clearing pass follows reset; the block is ready at once.
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last
);

  sha1_pkg::ctl_t               ctl;
  logic [7:0]                   blk_byte;
  logic [sha1_pkg::WORD_W-1:0]  w_cur;
  logic [sha1_pkg::IDX_W-1:0]   idx;

  // sequencer: byte intake, padding, round count, digest readout
  sha1_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .word_index   (idx),
    .byte_out     (blk_byte),
    .ctl          (ctl)
  );

  // block buffer doubling as the message schedule
  sha1_sched u_sched (
    .clk     (clk),
    .byte_in (blk_byte),
    .ctl     (ctl),
    .w_cur   (w_cur)
  );

  // working variables, round unit and chaining words
  sha1_comp u_comp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .w_cur       (w_cur),
    .digest_word (out_digest_word)
  );

  assign out_word_index = idx;
  assign out_last       = (idx == sha1_pkg::IDX_LAST);

endmodule
